[rtl/core/moetk_pkg.sv]
// Package for the mixture-of-experts top-k combine block.
// Holds command and register codes, sequencer states and the structs shared by the modules.
// No dependencies.
`default_nettype none

package moetk_pkg;

    localparam int VALUE_W = 16;
    localparam int PROB_W  = 13;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int RES_W   = 32;

    localparam logic [2:0] CMD_WEIGHT  = 3'd0;
    localparam logic [2:0] CMD_BIAS    = 3'd1;
    localparam logic [2:0] CMD_INPUT   = 3'd2;
    localparam logic [2:0] CMD_ROUTE   = 3'd3;
    localparam logic [2:0] CMD_COMPUTE = 3'd4;

    localparam logic [2:0] REG_EXPERTS  = 3'd0;
    localparam logic [2:0] REG_SLOTS    = 3'd1;
    localparam logic [2:0] REG_IN_WIDTH = 3'd2;
    localparam logic [2:0] REG_OUT_WID  = 3'd3;
    localparam logic [2:0] REG_BIAS_EN  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUT_START,
        S_SLOT,
        S_MAC,
        S_DRAIN,
        S_BIAS,
        S_PROB,
        S_ACC,
        S_ROUND,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [12:0] prob;
        logic [2:0]  expert;
    } route_t;

    typedef struct packed {
        logic [3:0] ne;
        logic [2:0] ns;
        logic [6:0] nin;
        logic [6:0] nout;
        logic       bias_en;
    } cfg_t;

    typedef struct packed {
        logic       w_en;
        logic       b_en;
        logic [2:0] expert;
    } mem_rd_t;

    typedef struct packed {
        logic mac_issue;
        logic dot_clr;
        logic bias_add;
        logic prob_mul;
        logic acc_clr;
        logic acc_add;
        logic round;
    } dp_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/moetk_if.sv]
// Valid/ready channel interfaces for requests and results of the combine block.
// Depends on nothing; payload widths follow the request and result fields.
`default_nettype none

interface moetk_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [2:0]  expert;
    logic [5:0]  out_index;
    logic [5:0]  in_index;
    logic [1:0]  slot;
    logic signed [15:0] value;
    logic [12:0] gate_prob;
    logic        route_expert_valid;

    modport source (output valid, cmd, expert, out_index, in_index, slot, value, gate_prob,
                    route_expert_valid, input ready);
    modport sink (input valid, cmd, expert, out_index, in_index, slot, value, gate_prob,
                  route_expert_valid, output ready);
endinterface

interface moetk_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  feature_index;
    logic signed [31:0] feature_value;
    logic        last;

    modport source (output valid, feature_index, feature_value, last, input ready);
    modport sink (input valid, feature_index, feature_value, last, output ready);
endinterface

`default_nettype wire

[rtl/core/moetk_store.sv]
// Weight, bias and token memories plus the routing table of the combine block.
// Depends on moetk_pkg; written by load requests, read by the sequencer.
`default_nettype none

module moetk_store #(
    parameter int EXPERTS_MAX = 8,
    parameter int IN_MAX      = 64,
    parameter int OUT_MAX     = 64,
    parameter int SLOTS_MAX   = 4
) (
    input  wire logic                 clk,
    input  wire logic                 wr_accept,
    input  wire logic [2:0]           wr_cmd,
    input  wire logic [2:0]           wr_expert,
    input  wire logic [5:0]           wr_out_index,
    input  wire logic [5:0]           wr_in_index,
    input  wire logic [1:0]           wr_slot,
    input  wire logic [15:0]          wr_value,
    input  wire logic [12:0]          wr_prob,
    input  wire logic                 wr_route_valid,
    input  wire moetk_pkg::mem_rd_t   rd,
    input  wire logic [(OUT_MAX > 1 ? $clog2(OUT_MAX) : 1)-1:0] rd_o,
    input  wire logic [(IN_MAX > 1 ? $clog2(IN_MAX) : 1)-1:0]   rd_i,
    input  wire logic [(SLOTS_MAX > 1 ? $clog2(SLOTS_MAX) : 1)-1:0] rd_slot,
    output moetk_pkg::route_t         route,
    output logic signed [15:0]        w_q,
    output logic signed [15:0]        x_q,
    output logic signed [15:0]        b_q
);

    localparam int W_DEPTH = EXPERTS_MAX * OUT_MAX * IN_MAX;
    localparam int B_DEPTH = EXPERTS_MAX * OUT_MAX;
    localparam int WA_W    = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
    localparam int BA_W    = B_DEPTH > 1 ? $clog2(B_DEPTH) : 1;
    localparam int I_W     = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
    localparam int S_W     = SLOTS_MAX > 1 ? $clog2(SLOTS_MAX) : 1;

    logic [15:0] w_mem [W_DEPTH];
    logic [15:0] b_mem [B_DEPTH];
    logic [15:0] x_mem [IN_MAX];
    moetk_pkg::route_t route_mem [SLOTS_MAX];

    logic            w_we;
    logic            b_we;
    logic            x_we;
    logic            r_we;
    logic [WA_W-1:0] w_waddr;
    logic [BA_W-1:0] b_waddr;
    logic [WA_W-1:0] w_raddr;
    logic [BA_W-1:0] b_raddr;

    always_comb
    begin
        w_we = wr_accept && (wr_cmd == moetk_pkg::CMD_WEIGHT) && (int'(wr_expert) < EXPERTS_MAX)
            && (int'(wr_out_index) < OUT_MAX) && (int'(wr_in_index) < IN_MAX);
        b_we = wr_accept && (wr_cmd == moetk_pkg::CMD_BIAS) && (int'(wr_expert) < EXPERTS_MAX)
            && (int'(wr_out_index) < OUT_MAX);
        x_we = wr_accept && (wr_cmd == moetk_pkg::CMD_INPUT) && (int'(wr_in_index) < IN_MAX);
        r_we = wr_accept && (wr_cmd == moetk_pkg::CMD_ROUTE) && (int'(wr_slot) < SLOTS_MAX);
        w_waddr = WA_W'(int'(wr_expert) * (OUT_MAX * IN_MAX) + int'(wr_out_index) * IN_MAX
            + int'(wr_in_index));
        b_waddr = BA_W'(int'(wr_expert) * OUT_MAX + int'(wr_out_index));
        w_raddr = WA_W'(int'(rd.expert) * (OUT_MAX * IN_MAX) + int'(rd_o) * IN_MAX + int'(rd_i));
        b_raddr = BA_W'(int'(rd.expert) * OUT_MAX + int'(rd_o));
        route = route_mem[rd_slot];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= wr_value;
        end
        if (rd.w_en)
        begin
            w_q <= $signed(w_mem[w_raddr]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[I_W'(wr_in_index)] <= wr_value;
        end
        if (rd.w_en)
        begin
            x_q <= $signed(x_mem[rd_i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= wr_value;
        end
        if (rd.b_en)
        begin
            b_q <= $signed(b_mem[b_raddr]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            route_mem[S_W'(wr_slot)] <= '{valid: wr_route_valid, prob: wr_prob,
                                          expert: wr_expert};
        end
    end

endmodule

`default_nettype wire

[rtl/core/moetk_datapath.sv]
// Shared multiply-accumulate datapath: product pipeline, dot accumulator, gate scaling,
// slot accumulator and final rounding with saturation. Depends on moetk_pkg.
`default_nettype none

module moetk_datapath #(
    parameter int IN_MAX    = 64,
    parameter int SLOTS_MAX = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire moetk_pkg::dp_ctrl_t ctrl,
    input  wire logic signed [15:0]  w_q,
    input  wire logic signed [15:0]  x_q,
    input  wire logic signed [15:0]  b_q,
    input  wire logic [12:0]         prob,
    output logic                     busy,
    output logic signed [31:0]       result
);

    localparam int DOT_W = 32 + $clog2(IN_MAX + 1) + 1;
    localparam int PP_W  = DOT_W + 14;
    localparam int ACC_W = PP_W + $clog2(SLOTS_MAX + 1) + 1;

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1 <<< 23);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    logic                    rd_vld_reg;
    logic                    mul_vld_reg;
    logic signed [31:0]      prod_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [DOT_W-1:0] dot_next;
    logic signed [PP_W-1:0]  pp_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shifted;
    logic signed [31:0]      result_reg;
    logic signed [31:0]      result_next;
    logic signed [DOT_W-1:0] bias_term;

    always_comb
    begin
        bias_term = {{(DOT_W - 28){b_q[15]}}, b_q, 12'b0};
        if (ctrl.dot_clr)
        begin
            dot_next = '0;
        end
        else if (mul_vld_reg)
        begin
            dot_next = dot_reg + DOT_W'(prod_reg);
        end
        else if (ctrl.bias_add)
        begin
            dot_next = dot_reg + bias_term;
        end
        else
        begin
            dot_next = dot_reg;
        end

        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + ACC_W'(pp_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end

        rnd = acc_reg + HALF;
        shifted = rnd >>> 24;
        if (shifted > SAT_MAX)
        begin
            result_next = 32'sh7fffffff;
        end
        else if (shifted < SAT_MIN)
        begin
            result_next = 32'sh80000000;
        end
        else
        begin
            result_next = 32'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= ctrl.mac_issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= x_q * w_q;
        end
        dot_reg <= dot_next;
        if (ctrl.prob_mul)
        begin
            pp_reg <= dot_reg * $signed({1'b0, prob});
        end
        acc_reg <= acc_next;
        if (ctrl.round)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = rd_vld_reg || mul_vld_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/moetk_seq.sv]
// Sequencer of the combine block: walks features, routing slots and input elements,
// drives the shared datapath and the memory reads. Depends on moetk_pkg.
`default_nettype none

module moetk_seq #(
    parameter int IN_MAX    = 64,
    parameter int OUT_MAX   = 64,
    parameter int SLOTS_MAX = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_accept,
    input  wire logic [2:0]          req_cmd,
    input  wire moetk_pkg::cfg_t     cfg,
    input  wire moetk_pkg::route_t   route,
    input  wire logic                busy,
    input  wire logic                out_free,
    output logic                     idle,
    output moetk_pkg::dp_ctrl_t      ctrl,
    output moetk_pkg::mem_rd_t       rd,
    output logic [(OUT_MAX > 1 ? $clog2(OUT_MAX) : 1)-1:0]     rd_o,
    output logic [(IN_MAX > 1 ? $clog2(IN_MAX) : 1)-1:0]       rd_i,
    output logic [(SLOTS_MAX > 1 ? $clog2(SLOTS_MAX) : 1)-1:0] rd_slot,
    output logic [12:0]              prob,
    output logic                     emit,
    output logic [5:0]               emit_index,
    output logic                     emit_last
);

    localparam int O_W = OUT_MAX > 1 ? $clog2(OUT_MAX) : 1;
    localparam int I_W = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
    localparam int S_W = SLOTS_MAX > 1 ? $clog2(SLOTS_MAX) : 1;

    moetk_pkg::state_t state_reg;
    moetk_pkg::state_t state_next;
    logic [O_W-1:0]    o_reg;
    logic [O_W-1:0]    o_next;
    logic [S_W-1:0]    s_reg;
    logic [S_W-1:0]    s_next;
    logic [I_W-1:0]    i_reg;
    logic [I_W-1:0]    i_next;
    logic [12:0]       prob_reg;
    logic [12:0]       prob_next;
    logic [2:0]        exp_reg;
    logic [2:0]        exp_next;
    logic              last_feature;
    logic              last_slot;
    logic              last_input;
    logic              slot_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= moetk_pkg::S_IDLE;
            o_reg     <= '0;
            s_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            o_reg     <= o_next;
            s_reg     <= s_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg <= prob_next;
        exp_reg  <= exp_next;
    end

    always_comb
    begin
        last_feature = (int'(o_reg) + 1) == int'(cfg.nout);
        last_slot    = (int'(s_reg) + 1) == int'(cfg.ns);
        last_input   = (int'(i_reg) + 1) == int'(cfg.nin);
        slot_active  = route.valid && ({1'b0, route.expert} < cfg.ne);

        state_next = state_reg;
        o_next     = o_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        prob_next  = prob_reg;
        exp_next   = exp_reg;
        idle       = 1'b0;
        ctrl       = '0;
        rd         = '{w_en: 1'b0, b_en: 1'b0, expert: exp_reg};
        emit       = 1'b0;

        case (state_reg)
            moetk_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (req_accept && (req_cmd == moetk_pkg::CMD_COMPUTE))
                begin
                    o_next     = '0;
                    state_next = moetk_pkg::S_OUT_START;
                end
            end
            moetk_pkg::S_OUT_START:
            begin
                ctrl.acc_clr = 1'b1;
                s_next       = '0;
                if (cfg.nout == '0)
                begin
                    state_next = moetk_pkg::S_IDLE;
                end
                else if (cfg.ns == '0)
                begin
                    state_next = moetk_pkg::S_ROUND;
                end
                else
                begin
                    state_next = moetk_pkg::S_SLOT;
                end
            end
            moetk_pkg::S_SLOT:
            begin
                rd.expert = route.expert;
                if (slot_active)
                begin
                    ctrl.dot_clr = 1'b1;
                    rd.b_en      = 1'b1;
                    prob_next    = route.prob;
                    exp_next     = route.expert;
                    i_next       = '0;
                    state_next   = (cfg.nin == '0) ? moetk_pkg::S_DRAIN : moetk_pkg::S_MAC;
                end
                else if (last_slot)
                begin
                    state_next = moetk_pkg::S_ROUND;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            moetk_pkg::S_MAC:
            begin
                ctrl.mac_issue = 1'b1;
                rd.w_en        = 1'b1;
                i_next         = i_reg + 1'b1;
                if (last_input)
                begin
                    state_next = moetk_pkg::S_DRAIN;
                end
            end
            moetk_pkg::S_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = moetk_pkg::S_BIAS;
                end
            end
            moetk_pkg::S_BIAS:
            begin
                ctrl.bias_add = cfg.bias_en;
                state_next    = moetk_pkg::S_PROB;
            end
            moetk_pkg::S_PROB:
            begin
                ctrl.prob_mul = 1'b1;
                state_next    = moetk_pkg::S_ACC;
            end
            moetk_pkg::S_ACC:
            begin
                ctrl.acc_add = 1'b1;
                if (last_slot)
                begin
                    state_next = moetk_pkg::S_ROUND;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = moetk_pkg::S_SLOT;
                end
            end
            moetk_pkg::S_ROUND:
            begin
                ctrl.round = 1'b1;
                state_next = moetk_pkg::S_EMIT;
            end
            moetk_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (last_feature)
                    begin
                        state_next = moetk_pkg::S_IDLE;
                    end
                    else
                    begin
                        o_next     = o_reg + 1'b1;
                        state_next = moetk_pkg::S_OUT_START;
                    end
                end
            end
            default:
            begin
                state_next = moetk_pkg::S_IDLE;
            end
        endcase
    end

    assign rd_o       = o_reg;
    assign rd_i       = i_reg;
    assign rd_slot    = s_reg;
    assign prob       = prob_reg;
    assign emit_index = 6'(o_reg);
    assign emit_last  = last_feature;

endmodule

`default_nettype wire

[rtl/core/moe_top_k_expert_combine.sv]
// Top level of the mixture-of-experts top-k combine block: configuration registers,
// result register and the store, datapath and sequencer. Depends on moetk_pkg and moetk_if.
//
// Load requests (weight, bias, input element, route slot) are taken one per cycle while the
// block is idle. A compute request then produces out_width results in feature order, the
// last one flagged. Each feature is computed by the single 16 by 16 multiply-accumulate
// unit, which walks the input elements of each active routing slot, one weight memory read
// per cycle; a slot that is invalid or selects an expert at or beyond experts_in_use is
// skipped. The request side is not ready during a compute. Results leave through a
// one-entry output register, so a compute stalls only when a finished result is still
// waiting to be taken.
`default_nettype none

module moe_top_k_expert_combine #(
    parameter int EXPERTS_MAX = 8,
    parameter int IN_MAX      = 64,
    parameter int OUT_MAX     = 64,
    parameter int SLOTS_MAX   = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    moetk_req_if.sink                            req,
    moetk_rsp_if.source                          rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [moetk_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [moetk_pkg::PDATA_W-1:0]   pwdata,
    output logic      [moetk_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready
);

    localparam int O_W = OUT_MAX > 1 ? $clog2(OUT_MAX) : 1;
    localparam int I_W = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
    localparam int S_W = SLOTS_MAX > 1 ? $clog2(SLOTS_MAX) : 1;

    logic [3:0] experts_reg;
    logic [2:0] slots_reg;
    logic [6:0] in_width_reg;
    logic [6:0] out_width_reg;
    logic       bias_en_reg;
    logic       cfg_we;
    logic [2:0] cfg_idx;

    moetk_pkg::cfg_t     cfg;
    moetk_pkg::route_t   route;
    moetk_pkg::mem_rd_t  rd;
    moetk_pkg::dp_ctrl_t ctrl;

    logic [O_W-1:0]     rd_o;
    logic [I_W-1:0]     rd_i;
    logic [S_W-1:0]     rd_slot;
    logic signed [15:0] w_q;
    logic signed [15:0] x_q;
    logic signed [15:0] b_q;
    logic [12:0]        prob;
    logic               busy;
    logic signed [31:0] result;
    logic               idle;
    logic               req_accept;
    logic               emit;
    logic [5:0]         emit_index;
    logic               emit_last;
    logic               out_free;

    logic               out_valid_reg;
    logic [5:0]         out_index_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;

    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            experts_reg   <= 4'd8;
            slots_reg     <= 3'd2;
            in_width_reg  <= 7'd64;
            out_width_reg <= 7'd64;
            bias_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                moetk_pkg::REG_EXPERTS:  experts_reg   <= pwdata[3:0];
                moetk_pkg::REG_SLOTS:    slots_reg     <= pwdata[2:0];
                moetk_pkg::REG_IN_WIDTH: in_width_reg  <= pwdata[6:0];
                moetk_pkg::REG_OUT_WID:  out_width_reg <= pwdata[6:0];
                moetk_pkg::REG_BIAS_EN:  bias_en_reg   <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            moetk_pkg::REG_EXPERTS:  prdata = {28'b0, experts_reg};
            moetk_pkg::REG_SLOTS:    prdata = {29'b0, slots_reg};
            moetk_pkg::REG_IN_WIDTH: prdata = {25'b0, in_width_reg};
            moetk_pkg::REG_OUT_WID:  prdata = {25'b0, out_width_reg};
            moetk_pkg::REG_BIAS_EN:  prdata = {31'b0, bias_en_reg};
            default:                 prdata = '0;
        endcase

        cfg.ne      = (int'(experts_reg) > EXPERTS_MAX) ? 4'(EXPERTS_MAX) : experts_reg;
        cfg.ns      = (int'(slots_reg) > SLOTS_MAX) ? 3'(SLOTS_MAX) : slots_reg;
        cfg.nin     = (int'(in_width_reg) > IN_MAX) ? 7'(IN_MAX) : in_width_reg;
        cfg.nout    = (int'(out_width_reg) > OUT_MAX) ? 7'(OUT_MAX) : out_width_reg;
        cfg.bias_en = bias_en_reg;
    end

    assign req.ready  = idle;
    assign req_accept = req.valid && idle;
    assign out_free   = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_index_reg <= emit_index;
            out_value_reg <= result;
            out_last_reg  <= emit_last;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.feature_index = out_index_reg;
    assign rsp.feature_value = out_value_reg;
    assign rsp.last          = out_last_reg;

    moetk_store #(
        .EXPERTS_MAX (EXPERTS_MAX),
        .IN_MAX      (IN_MAX),
        .OUT_MAX     (OUT_MAX),
        .SLOTS_MAX   (SLOTS_MAX)
    ) u_store (
        .clk            (clk),
        .wr_accept      (req_accept),
        .wr_cmd         (req.cmd),
        .wr_expert      (req.expert),
        .wr_out_index   (req.out_index),
        .wr_in_index    (req.in_index),
        .wr_slot        (req.slot),
        .wr_value       (req.value),
        .wr_prob        (req.gate_prob),
        .wr_route_valid (req.route_expert_valid),
        .rd             (rd),
        .rd_o           (rd_o),
        .rd_i           (rd_i),
        .rd_slot        (rd_slot),
        .route          (route),
        .w_q            (w_q),
        .x_q            (x_q),
        .b_q            (b_q)
    );

    moetk_datapath #(
        .IN_MAX    (IN_MAX),
        .SLOTS_MAX (SLOTS_MAX)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .w_q    (w_q),
        .x_q    (x_q),
        .b_q    (b_q),
        .prob   (prob),
        .busy   (busy),
        .result (result)
    );

    moetk_seq #(
        .IN_MAX    (IN_MAX),
        .OUT_MAX   (OUT_MAX),
        .SLOTS_MAX (SLOTS_MAX)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .req_cmd    (req.cmd),
        .cfg        (cfg),
        .route      (route),
        .busy       (busy),
        .out_free   (out_free),
        .idle       (idle),
        .ctrl       (ctrl),
        .rd         (rd),
        .rd_o       (rd_o),
        .rd_i       (rd_i),
        .rd_slot    (rd_slot),
        .prob       (prob),
        .emit       (emit),
        .emit_index (emit_index),
        .emit_last  (emit_last)
    );

endmodule

`default_nettype wire

[rtl/core/moetk_checker.sv]
// Port-level checker for the combine block, attached to the top level by a bind.
// Depends on moetk_pkg for the compute command code.
`default_nettype none

module moetk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic [2:0]  req_cmd,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [5:0]  rsp_feature_index,
    input wire logic [31:0] rsp_feature_value,
    input wire logic        rsp_last
);

    // A waiting result stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_feature_index) && $stable(rsp_feature_value)
            && $stable(rsp_last))
        else $error("stalled result changed");

    // While a compute run is unfinished, no request is taken.
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request side ready in the middle of a compute run");

    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == moetk_pkg::CMD_COMPUTE) |=> !req_ready)
        else $error("request side still ready after a compute request");

endmodule

bind moe_top_k_expert_combine moetk_checker u_moetk_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_cmd           (req.cmd),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_feature_index (rsp.feature_index),
    .rsp_feature_value (rsp.feature_value),
    .rsp_last          (rsp.last)
);

`default_nettype wire
